>>> rtl/mtfw_pkg.sv
package mtfw_pkg;

	localparam int NUM_MUTEXES = 16;
	localparam int NUM_THREADS = 64;

	localparam int CMD_W = 2;
	localparam int IDX_W = 6;
	localparam int PID_W = 6;
	localparam int OWN_W = 7;
	localparam int RC_W  = 3;
	localparam int LV_W  = 8;

	localparam int MIDX_W = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
	localparam int TID_W  = $clog2(NUM_THREADS);

	localparam logic [OWN_W-1:0] NO_OWNER = OWN_W'(64);

	localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOCK    = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNLOCK  = 2'd3;

	localparam logic [RC_W-1:0] RC_OK            = 3'd0;
	localparam logic [RC_W-1:0] RC_INVALID       = 3'd1;
	localparam logic [RC_W-1:0] RC_NOT_OWNER     = 3'd2;
	localparam logic [RC_W-1:0] RC_HAS_WAITERS   = 3'd3;
	localparam logic [RC_W-1:0] RC_ALREADY_YOURS = 3'd4;
	localparam logic [RC_W-1:0] RC_NOT_LOCKED    = 3'd5;
	localparam logic [RC_W-1:0] RC_NONE_FREE     = 3'd6;

	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 24;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [IDX_W-1:0] mutex_index;
		logic [PID_W-1:0] caller_pid;
		logic             idx_ok;
		logic             pid_ok;
	} req_t;

	typedef struct packed {
		logic [RC_W-1:0]  result_code;
		logic [IDX_W-1:0] created_index;
		logic             caller_blocked;
		logic             woke_valid;
		logic [PID_W-1:0] woken_pid;
	} rsp_t;

endpackage

>>> rtl/mtfw_front.sv
module mtfw_front (
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [mtfw_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [mtfw_pkg::CMD_W-1:0]     s_tuser,
	input  logic                           q_full,
	output logic                           q_push,
	output mtfw_pkg::req_t                 q_req
);
	import mtfw_pkg::*;

	logic [IDX_W-1:0] idx;
	logic [PID_W-1:0] pid;

	assign idx = s_tdata[IDX_W-1:0];
	assign pid = s_tdata[IDX_W+PID_W-1:IDX_W];

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_req.command     = s_tuser;
		q_req.mutex_index = idx;
		q_req.caller_pid  = pid;
		q_req.idx_ok      = ({1'b0, idx} < (IDX_W+1)'(NUM_MUTEXES));
		q_req.pid_ok      = ({1'b0, pid} < (PID_W+1)'(NUM_THREADS));
	end

endmodule

>>> rtl/mtfw_queue.sv
module mtfw_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mtfw_pkg::req_t push_req,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output mtfw_pkg::req_t pop_req
);
	import mtfw_pkg::*;

	req_t       slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_req   = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

>>> rtl/mtfw_back.sv
module mtfw_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_not_empty,
	input  mtfw_pkg::req_t q_req,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output mtfw_pkg::rsp_t out_rsp
);
	import mtfw_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;

	logic                    in_use_q [NUM_MUTEXES];
	logic [OWN_W-1:0]        owner_q  [NUM_MUTEXES];
	logic signed [LV_W-1:0]  lock_q   [NUM_MUTEXES];
	logic [PID_W-1:0]        head_q   [NUM_MUTEXES];
	logic [PID_W-1:0]        tail_q   [NUM_MUTEXES];

	logic [PID_W-1:0] link_mem [NUM_THREADS];
	logic [PID_W-1:0] link_rd_q;
	logic [TID_W-1:0] link_raddr;
	logic             link_we;
	logic [TID_W-1:0] link_waddr;

	req_t cur_q;
	logic out_valid_q;
	rsp_t out_q;

	logic [MIDX_W-1:0] pop_e;
	logic [MIDX_W-1:0] e;
	logic              exec_go;
	logic              free_found;
	logic [MIDX_W-1:0] free_idx;

	logic signed [LV_W-1:0] lv;
	logic signed [LV_W-1:0] lv_dn;
	logic signed [LV_W-1:0] lv_up;
	logic [OWN_W-1:0]       pid_ext;
	logic [PID_W-1:0]       head;
	logic [PID_W-1:0]       tail;
	logic                   owner_match;
	logic                   head_in_range;
	logic                   tail_in_range;

	rsp_t rsp;
	logic do_create;
	logic do_destroy;
	logic do_lock;
	logic do_unlock;
	logic unlock_wake;

	assign pop_e      = q_req.mutex_index[MIDX_W-1:0];
	assign e          = cur_q.mutex_index[MIDX_W-1:0];
	assign link_raddr = head_q[pop_e][TID_W-1:0];

	assign q_pop     = (state_q == ST_IDLE) && q_not_empty;
	assign exec_go   = (state_q == ST_EXEC) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_rsp   = out_q;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_MUTEXES - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_found = 1'b1;
				free_idx   = MIDX_W'(i);
			end
		end
	end

	assign lv            = lock_q[e];
	assign lv_dn         = lv - 8'sd1;
	assign lv_up         = lv + 8'sd1;
	assign pid_ext       = {1'b0, cur_q.caller_pid};
	assign head          = head_q[e];
	assign tail          = tail_q[e];
	assign owner_match   = (owner_q[e] == pid_ext);
	assign head_in_range = ({1'b0, head} < (PID_W+1)'(NUM_THREADS));
	assign tail_in_range = ({1'b0, tail} < (PID_W+1)'(NUM_THREADS));

	always_comb begin
		rsp         = '0;
		do_create   = 1'b0;
		do_destroy  = 1'b0;
		do_lock     = 1'b0;
		do_unlock   = 1'b0;
		unlock_wake = 1'b0;
		link_we     = 1'b0;
		link_waddr  = tail[TID_W-1:0];
		rsp.result_code = RC_OK;
		if (cur_q.command == CMD_CREATE) begin
			if (!free_found) begin
				rsp.result_code = RC_NONE_FREE;
			end else begin
				do_create         = 1'b1;
				rsp.created_index = IDX_W'(free_idx);
			end
		end else if (!cur_q.idx_ok || !in_use_q[e]) begin
			rsp.result_code = RC_INVALID;
		end else begin
			case (cur_q.command)
				CMD_DESTROY: begin
					if (!owner_match) begin
						rsp.result_code = RC_NOT_OWNER;
					end else if (lv < 0) begin
						rsp.result_code = RC_HAS_WAITERS;
					end else begin
						do_destroy = 1'b1;
					end
				end
				CMD_LOCK: begin
					if (!cur_q.pid_ok) begin
						rsp.result_code = RC_NOT_OWNER;
					end else if (lv <= 0 && owner_match) begin
						rsp.result_code = RC_ALREADY_YOURS;
					end else if (lv == -8'sd128) begin
						rsp.result_code = RC_NONE_FREE;
					end else begin
						do_lock = 1'b1;
						if (lv_dn < 0) begin
							rsp.caller_blocked = 1'b1;
							link_we = (lv_dn != -8'sd1) && tail_in_range;
						end
					end
				end
				default: begin
					if (!owner_match) begin
						rsp.result_code = RC_NOT_OWNER;
					end else if (lv > 0) begin
						rsp.result_code = RC_NOT_LOCKED;
					end else begin
						do_unlock = 1'b1;
						if (lv_up <= 0) begin
							unlock_wake    = 1'b1;
							rsp.woke_valid = 1'b1;
							rsp.woken_pid  = head;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go && link_we) begin
			link_mem[link_waddr] <= cur_q.caller_pid;
		end
		if (q_pop) begin
			link_rd_q <= link_mem[link_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_req;
		end
		if (exec_go) begin
			out_q <= rsp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_MUTEXES; i++) begin
				in_use_q[i] <= 1'b0;
				owner_q[i]  <= NO_OWNER;
				lock_q[i]   <= 8'sd1;
				head_q[i]   <= '0;
				tail_q[i]   <= '0;
			end
		end else begin
			if (out_valid_q && out_ready && !exec_go) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_go) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
						if (do_create) begin
							in_use_q[free_idx] <= 1'b1;
							owner_q[free_idx]  <= NO_OWNER;
							lock_q[free_idx]   <= 8'sd1;
							head_q[free_idx]   <= '0;
							tail_q[free_idx]   <= '0;
						end
						if (do_destroy) begin
							in_use_q[e] <= 1'b0;
							owner_q[e]  <= NO_OWNER;
						end
						if (do_lock) begin
							lock_q[e] <= lv_dn;
							if (lv_dn < 0) begin
								if (lv_dn == -8'sd1) begin
									head_q[e] <= cur_q.caller_pid;
								end
								tail_q[e] <= cur_q.caller_pid;
							end else begin
								owner_q[e] <= pid_ext;
							end
						end
						if (do_unlock) begin
							lock_q[e] <= lv_up;
							if (unlock_wake) begin
								if (head_in_range) begin
									head_q[e] <= link_rd_q;
								end
								owner_q[e] <= {1'b0, head};
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/mutex_table_with_fifo_waiters_top.sv
// Mutex table with FIFO wait queues. Each input transaction is one command (create, destroy,
// lock or unlock) from one caller and yields exactly one result transaction. The front end
// decodes the command, range-checks its mutex index and caller pid, and places it in a
// two-entry queue, so the input keeps accepting while the back end works and the queue has
// room. The back end handles each transaction in two steps: the first reads the waiter-link
// memory at the head of the addressed queue, and the second, which waits while an earlier
// result is not yet taken, updates the mutex table and loads the output register. It takes
// a new transaction only after finishing the last one. The table is ready right after reset.
module mutex_table_with_fifo_waiters_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// mutex_index [5:0], caller_pid [11:6], zero fill [15:12]
	input  logic [mtfw_pkg::S_TDATA_W-1:0] s_tdata,
	// command [1:0]
	input  logic [mtfw_pkg::CMD_W-1:0]     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// result_code [2:0], created_index [8:3], caller_blocked [9], woke_valid [10],
	// woken_pid [16:11], zero fill [23:17]
	output logic [mtfw_pkg::M_TDATA_W-1:0] m_tdata
);
	import mtfw_pkg::*;

	logic q_full;
	logic q_push;
	req_t q_in;
	logic q_pop;
	logic q_not_empty;
	req_t q_out;
	rsp_t rsp;

	mtfw_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_req    (q_in)
	);

	mtfw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_req  (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_req   (q_out)
	);

	mtfw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_req       (q_out),
		.q_pop       (q_pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_rsp     (rsp)
	);

	assign m_tdata = {7'd0, rsp.woken_pid, rsp.woke_valid, rsp.caller_blocked,
		rsp.created_index, rsp.result_code};

endmodule
